@@ hdl/tsrb_pkg.sv @@
`default_nettype none

package tsrb_pkg;

    localparam int STORE_DEPTH = 16;
    localparam int TIME_BITS   = 48;
    localparam int TAG_W       = 16;
    localparam int TYPE_W      = 16;
    localparam int MARGIN_W    = 32;
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int CMP_W       = (TIME_BITS > MARGIN_W) ? TIME_BITS : MARGIN_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_TYPE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_MARGIN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_SET_CODE = 2'd2;

    localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
    localparam logic [1:0] STATUS_TOO_OLD  = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef struct packed {
        logic       load;
        logic       insert;
        logic       pop;
        logic       emit_release;
        logic       emit_status;
        logic [1:0] status_code;
    } cmd_t;

    typedef struct packed {
        logic too_old;
        logic full;
        logic release_ok;
    } stat_t;

endpackage

`default_nettype wire

@@ hdl/timestamp_reorder_release_buffer_top.sv @@
// a taken start loads the word; a refused word then gives its registered status word
// an accepted word is inserted, then gives n released words and then its status word
// start is taken only when idle; a new word waits for the last one's status (n up to 16)
// results come out as single-cycle strobed words, the receiver cannot stall
// reset: asynchronous active-low rst_n empties the store, clears the last released time
// and the config registers, and returns the controller to idle
`default_nettype none

module timestamp_reorder_release_buffer_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tsrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [tsrb_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic [tsrb_pkg::TIME_BITS-1:0]    arrival_time,
    input  wire logic [tsrb_pkg::TYPE_W-1:0]       sensor_type,
    input  wire logic                              has_elements,
    input  wire logic [tsrb_pkg::TAG_W-1:0]        payload_tag,
    output logic                                   result_strobe,
    output logic                                   result_kind,
    output logic [tsrb_pkg::TIME_BITS-1:0]         entry_time,
    output logic [tsrb_pkg::TAG_W-1:0]             entry_tag,
    output logic [1:0]                             status_code,
    output logic                                   last_result
);
    import tsrb_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    tsrb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tsrb_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .arrival_time  (arrival_time),
        .sensor_type   (sensor_type),
        .has_elements  (has_elements),
        .payload_tag   (payload_tag),
        .result_strobe (result_strobe),
        .result_kind   (result_kind),
        .entry_time    (entry_time),
        .entry_tag     (entry_tag),
        .status_code   (status_code),
        .last_result   (last_result)
    );

`ifndef SYNTHESIS
    // finishing a word always puts its status word out
    a_done_gives_status: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_strobe && last_result))
        else $error("busy fell without a final status word");

    // released words only appear while the word is still in progress
    a_release_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last_result) |-> busy)
        else $error("non-final result outside of a busy period");

    // a taken start makes the block busy
    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start taken but block not busy");
`endif

endmodule

`default_nettype wire

@@ hdl/tsrb_ctrl.sv @@
`default_nettype none

module tsrb_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire tsrb_pkg::stat_t stat,
    output tsrb_pkg::cmd_t     cmd,
    output logic               busy
);
    import tsrb_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_EVAL  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (stat.too_old)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status_code = STATUS_TOO_OLD;
                    state_next      = ST_IDLE;
                end
                else if (stat.full)
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status_code = STATUS_FULL;
                    state_next      = ST_IDLE;
                end
                else
                begin
                    cmd.insert = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (stat.release_ok)
                begin
                    cmd.pop          = 1'b1;
                    cmd.emit_release = 1'b1;
                end
                else
                begin
                    cmd.emit_status = 1'b1;
                    cmd.status_code = STATUS_ACCEPTED;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

@@ hdl/tsrb_datapath.sv @@
`default_nettype none

module tsrb_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire tsrb_pkg::cmd_t                      cmd,
    output tsrb_pkg::stat_t                          stat,
    input  wire logic                                cfg_wr_en,
    input  wire logic [tsrb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [tsrb_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  wire logic [tsrb_pkg::TIME_BITS-1:0]      arrival_time,
    input  wire logic [tsrb_pkg::TYPE_W-1:0]         sensor_type,
    input  wire logic                                has_elements,
    input  wire logic [tsrb_pkg::TAG_W-1:0]          payload_tag,
    output logic                                     result_strobe,
    output logic                                     result_kind,
    output logic [tsrb_pkg::TIME_BITS-1:0]           entry_time,
    output logic [tsrb_pkg::TAG_W-1:0]               entry_tag,
    output logic [1:0]                               status_code,
    output logic                                     last_result
);
    import tsrb_pkg::*;

    logic [TYPE_W-1:0]    trigger_type_reg;
    logic [MARGIN_W-1:0]  trigger_margin_reg;
    logic [TYPE_W-1:0]    empty_set_code_reg;

    logic [TIME_BITS-1:0] in_time_reg;
    logic [TYPE_W-1:0]    in_type_reg;
    logic                 in_nonempty_reg;
    logic [TAG_W-1:0]     in_tag_reg;

    logic [TIME_BITS-1:0] store_time_reg [STORE_DEPTH];
    logic [TAG_W-1:0]     store_tag_reg  [STORE_DEPTH];
    logic [TIME_BITS-1:0] store_time_next [STORE_DEPTH];
    logic [TAG_W-1:0]     store_tag_next  [STORE_DEPTH];

    logic [CNT_W-1:0]     count_reg;
    logic [TIME_BITS-1:0] last_rel_reg;
    logic                 trig_reg;

    logic                 result_strobe_reg;
    logic                 result_kind_reg;
    logic [TIME_BITS-1:0] entry_time_reg;
    logic [TAG_W-1:0]     entry_tag_reg;
    logic [1:0]           status_code_reg;
    logic                 last_result_reg;

    logic [STORE_DEPTH-1:0] le;
    logic [STORE_DEPTH-1:0] le_prev;
    logic [TIME_BITS-1:0]   time_up [STORE_DEPTH];
    logic [TAG_W-1:0]       tag_up  [STORE_DEPTH];
    logic [TIME_BITS-1:0]   time_dn [STORE_DEPTH];
    logic [TAG_W-1:0]       tag_dn  [STORE_DEPTH];
    logic                   trig_now;
    logic [TIME_BITS-1:0]   front_diff;
    logic                   front_due;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trigger_type_reg   <= '0;
            trigger_margin_reg <= '0;
            empty_set_code_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TRIGGER_TYPE:   trigger_type_reg   <= cfg_wr_data[TYPE_W-1:0];
                REG_TRIGGER_MARGIN: trigger_margin_reg <= cfg_wr_data[MARGIN_W-1:0];
                REG_EMPTY_SET_CODE: empty_set_code_reg <= cfg_wr_data[TYPE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // input word latch
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_time_reg     <= arrival_time;
            in_type_reg     <= sensor_type;
            in_nonempty_reg <= has_elements;
            in_tag_reg      <= payload_tag;
        end
    end

    // per-entry compare and neighbor taps
    always_comb
    begin
        for (int j = 0; j < STORE_DEPTH; j++)
        begin
            le[j] = (CNT_W'(j) < count_reg) && (store_time_reg[j] <= in_time_reg);
        end
        le_prev[0] = 1'b1;
        time_up[0] = store_time_reg[0];
        tag_up[0]  = store_tag_reg[0];
        for (int j = 1; j < STORE_DEPTH; j++)
        begin
            le_prev[j] = le[j-1];
            time_up[j] = store_time_reg[j-1];
            tag_up[j]  = store_tag_reg[j-1];
        end
        time_dn[STORE_DEPTH-1] = store_time_reg[STORE_DEPTH-1];
        tag_dn[STORE_DEPTH-1]  = store_tag_reg[STORE_DEPTH-1];
        for (int j = 0; j < STORE_DEPTH - 1; j++)
        begin
            time_dn[j] = store_time_reg[j+1];
            tag_dn[j]  = store_tag_reg[j+1];
        end
    end

    // shift insert and front pop
    always_comb
    begin
        for (int j = 0; j < STORE_DEPTH; j++)
        begin
            store_time_next[j] = store_time_reg[j];
            store_tag_next[j]  = store_tag_reg[j];
            if (cmd.insert)
            begin
                if (le[j])
                begin
                    store_time_next[j] = store_time_reg[j];
                    store_tag_next[j]  = store_tag_reg[j];
                end
                else if (le_prev[j])
                begin
                    store_time_next[j] = in_time_reg;
                    store_tag_next[j]  = in_tag_reg;
                end
                else
                begin
                    store_time_next[j] = time_up[j];
                    store_tag_next[j]  = tag_up[j];
                end
            end
            else if (cmd.pop)
            begin
                store_time_next[j] = time_dn[j];
                store_tag_next[j]  = tag_dn[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        store_time_reg <= store_time_next;
        store_tag_reg  <= store_tag_next;
    end

    assign trig_now = (in_nonempty_reg && (in_type_reg == trigger_type_reg)) ||
                      (!in_nonempty_reg && (trigger_type_reg == empty_set_code_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            last_rel_reg <= '0;
            trig_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.insert)
            begin
                count_reg <= count_reg + CNT_W'(1);
                trig_reg  <= trig_now;
            end
            else if (cmd.pop)
            begin
                count_reg    <= count_reg - CNT_W'(1);
                last_rel_reg <= store_time_reg[0];
            end
        end
    end

    // release test on the oldest entry
    assign front_diff = in_time_reg - store_time_reg[0];
    assign front_due  = (store_time_reg[0] <= in_time_reg) &&
                        (CMP_W'(front_diff) >= CMP_W'(trigger_margin_reg));

    assign stat.too_old    = (in_time_reg < last_rel_reg);
    assign stat.full       = (count_reg == CNT_W'(STORE_DEPTH));
    assign stat.release_ok = trig_reg && (count_reg != '0) && front_due;

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_strobe_reg <= 1'b0;
        end
        else
        begin
            result_strobe_reg <= cmd.emit_release || cmd.emit_status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_release)
        begin
            result_kind_reg <= KIND_RELEASE;
            entry_time_reg  <= store_time_reg[0];
            entry_tag_reg   <= store_tag_reg[0];
            status_code_reg <= STATUS_ACCEPTED;
            last_result_reg <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            result_kind_reg <= KIND_STATUS;
            entry_time_reg  <= '0;
            entry_tag_reg   <= '0;
            status_code_reg <= cmd.status_code;
            last_result_reg <= 1'b1;
        end
    end

    assign result_strobe = result_strobe_reg;
    assign result_kind   = result_kind_reg;
    assign entry_time    = entry_time_reg;
    assign entry_tag     = entry_tag_reg;
    assign status_code   = status_code_reg;
    assign last_result   = last_result_reg;

endmodule

`default_nettype wire
